@@ src/tasrl_pkg.sv @@
// Shared types, codes, reset values and clamp helper for the two-axis slew-rate limiter.
`default_nettype none
package tasrl_pkg;

  localparam int PosW  = 20;
  localparam int LimW  = 19;
  localparam int RateW = 16;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [LimW-1:0]        lim_t;
  typedef logic [RateW-1:0]       rate_t;

  // Item kinds; the fourth code is unused and is dropped without a result.
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_AZ_LIMIT   = 2'd0,
    CFG_EL_LIMIT   = 2'd1,
    CFG_RATE_FLOOR = 2'd2,
    CFG_RATE_CEIL  = 2'd3
  } cfg_idx_t;

  localparam lim_t  AzLimitRst   = lim_t'(180000);
  localparam lim_t  ElLimitRst   = lim_t'(90000);
  localparam rate_t RateFloorRst = rate_t'(1);
  localparam rate_t RateCeilRst  = rate_t'(600);

  // Result of one axis step, handed from the axis unit to the top level.
  typedef struct packed {
    pos_t next;
    logic big;
  } axis_res_t;

  // Clamp a signed position to the symmetric range [-lim, lim].
  function automatic pos_t clamp_sym(pos_t v, lim_t lim);
    logic signed [PosW:0] vx;
    logic signed [PosW:0] hi;
    logic signed [PosW:0] lo;
    pos_t                 res;
    vx = {v[PosW-1], v};
    hi = $signed({{(PosW + 1 - LimW){1'b0}}, lim});
    lo = -hi;
    if (vx > hi) begin
      res = hi[PosW-1:0];
    end else if (vx < lo) begin
      res = lo[PosW-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/tasrl_axis.sv @@
// One axis step toward its goal, limited to the slew step.
`default_nettype none
module tasrl_axis (
  input  wire tasrl_pkg::pos_t  cur,
  input  wire tasrl_pkg::pos_t  goal,
  input  wire tasrl_pkg::rate_t step,
  output tasrl_pkg::axis_res_t  res
);
  import tasrl_pkg::*;

  logic signed [PosW:0] diff;
  logic [PosW:0]        mag;
  logic                 reach;
  pos_t                 stepx;

  always_comb begin
    diff  = $signed({goal[PosW-1], goal}) - $signed({cur[PosW-1], cur});
    mag   = diff[PosW] ? (PosW + 1)'(-diff) : (PosW + 1)'(diff);
    reach = mag <= {{(PosW + 1 - RateW){1'b0}}, step};
    stepx = pos_t'({{(PosW - RateW){1'b0}}, step});
    if (reach) begin
      res.next = goal;
      // The change equals the full distance when the goal is reached.
      res.big  = mag > (PosW + 1)'(1);
    end else begin
      res.next = diff[PosW] ? (cur - stepx) : (cur + stepx);
      res.big  = step > RateW'(1);
    end
  end

endmodule
`default_nettype wire

@@ src/two_axis_slew_rate_limiter_top.sv @@
// Top level of the two-axis slew-rate limited positioner.
// Flow: an accepted item waits in the stage register and is applied to the state as it leaves,
// where a tick's result is loaded into the output register that drives the out_ ports.
// Throughput: one item per cycle; only a stalled tick result holds up the pipe.
// Reset: synchronous active-low rst_n clears positions, goals, rates and flags,
// empties both stages and reloads the limit registers with their defaults.
`default_nettype none
module two_axis_slew_rate_limiter_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input item channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire tasrl_pkg::pos_t   in_want_azimuth,
  input  wire tasrl_pkg::pos_t   in_want_elevation,
  input  wire tasrl_pkg::rate_t  in_want_rate,
  // Result item channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tasrl_pkg::pos_t        out_azimuth_now,
  output tasrl_pkg::pos_t        out_elevation_now,
  output logic                   out_in_motion,
  output tasrl_pkg::rate_t       out_rate_now,
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [18:0]       cfg_data
);
  import tasrl_pkg::*;

  // Limit registers.
  lim_t  az_limit_r, el_limit_r;
  rate_t rate_floor_r, rate_ceil_r;

  // Stage register: the accepted item waiting to be applied to the state.
  logic  s1_valid_r, s1_valid_nxt;
  kind_t s1_kind_r;
  pos_t  s1_az_r, s1_el_r;
  rate_t s1_rate_r;

  // Positioner state.
  pos_t  az_pos_r, az_pos_nxt;
  pos_t  el_pos_r, el_pos_nxt;
  pos_t  az_goal_r, az_goal_nxt;
  pos_t  el_goal_r, el_goal_nxt;
  rate_t goal_rate_r, goal_rate_nxt;
  logic  moving_r, moving_nxt;
  rate_t rep_rate_r, rep_rate_nxt;
  logic  halted_r, halted_nxt;

  // Output register.
  logic  out_valid_r, out_valid_nxt;
  pos_t  out_az_r, out_el_r;
  logic  out_motion_r;
  rate_t out_rate_r;

  logic      in_fire, s1_fire, s1_tick, cfg_fire;
  rate_t     rate_up, rate_clamped;
  axis_res_t az_res, el_res;

  // Always writable; the user ensures writes arrive only while the block is idle (unchecked).
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // A tick in the stage needs room in the output register; other kinds never wait.
  assign s1_tick  = s1_valid_r && (s1_kind_r == KIND_TICK);
  assign s1_fire  = s1_valid_r && (!s1_tick || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  tasrl_axis u_az (
    .cur  (az_pos_r),
    .goal (az_goal_r),
    .step (goal_rate_r),
    .res  (az_res)
  );

  tasrl_axis u_el (
    .cur  (el_pos_r),
    .goal (el_goal_r),
    .step (goal_rate_r),
    .res  (el_res)
  );

  // Requested rate: raised to the floor first, then the ceiling wins.
  assign rate_up      = (s1_rate_r < rate_floor_r) ? rate_floor_r : s1_rate_r;
  assign rate_clamped = (rate_up > rate_ceil_r) ? rate_ceil_r : rate_up;

  always_comb begin
    az_pos_nxt    = az_pos_r;
    el_pos_nxt    = el_pos_r;
    az_goal_nxt   = az_goal_r;
    el_goal_nxt   = el_goal_r;
    goal_rate_nxt = goal_rate_r;
    moving_nxt    = moving_r;
    rep_rate_nxt  = rep_rate_r;
    halted_nxt    = halted_r;
    if (s1_fire) begin
      case (s1_kind_r)
        KIND_SET: begin
          az_goal_nxt   = clamp_sym(s1_az_r, az_limit_r);
          el_goal_nxt   = clamp_sym(s1_el_r, el_limit_r);
          goal_rate_nxt = rate_clamped;
          halted_nxt    = 1'b0;
        end
        KIND_STOP: begin
          // Freeze the goal where the axes stand and drop the rate.
          az_goal_nxt   = az_pos_r;
          el_goal_nxt   = el_pos_r;
          goal_rate_nxt = '0;
          moving_nxt    = 1'b0;
          rep_rate_nxt  = '0;
          halted_nxt    = 1'b1;
        end
        KIND_TICK: begin
          if (!halted_r) begin
            az_pos_nxt   = az_res.next;
            el_pos_nxt   = el_res.next;
            moving_nxt   = az_res.big || el_res.big;
            rep_rate_nxt = (az_res.big || el_res.big) ? goal_rate_r : '0;
          end
        end
        default: begin
          // Unused kind: dropped with no effect.
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control, state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      az_pos_r     <= '0;
      el_pos_r     <= '0;
      az_goal_r    <= '0;
      el_goal_r    <= '0;
      goal_rate_r  <= '0;
      moving_r     <= 1'b0;
      rep_rate_r   <= '0;
      halted_r     <= 1'b0;
      az_limit_r   <= AzLimitRst;
      el_limit_r   <= ElLimitRst;
      rate_floor_r <= RateFloorRst;
      rate_ceil_r  <= RateCeilRst;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      az_pos_r    <= az_pos_nxt;
      el_pos_r    <= el_pos_nxt;
      az_goal_r   <= az_goal_nxt;
      el_goal_r   <= el_goal_nxt;
      goal_rate_r <= goal_rate_nxt;
      moving_r    <= moving_nxt;
      rep_rate_r  <= rep_rate_nxt;
      halted_r    <= halted_nxt;
      if (cfg_fire) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AZ_LIMIT:   az_limit_r   <= cfg_data;
          CFG_EL_LIMIT:   el_limit_r   <= cfg_data;
          CFG_RATE_FLOOR: rate_floor_r <= cfg_data[RateW-1:0];
          CFG_RATE_CEIL:  rate_ceil_r  <= cfg_data[RateW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers; they load only when their stage takes a new item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_az_r   <= in_want_azimuth;
      s1_el_r   <= in_want_elevation;
      s1_rate_r <= in_want_rate;
    end
    if (s1_fire && s1_tick) begin
      out_az_r     <= az_pos_nxt;
      out_el_r     <= el_pos_nxt;
      out_motion_r <= moving_nxt;
      out_rate_r   <= rep_rate_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_azimuth_now   = out_az_r;
  assign out_elevation_now = out_el_r;
  assign out_in_motion     = out_motion_r;
  assign out_rate_now      = out_rate_r;

endmodule
`default_nettype wire

@@ src/tasrl_checker.sv @@
// Port-level checks for the two-axis slew-rate limiter, bound to its top level.
`default_nettype none
module tasrl_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire tasrl_pkg::pos_t  out_azimuth_now,
  input wire tasrl_pkg::pos_t  out_elevation_now,
  input wire logic             out_in_motion,
  input wire tasrl_pkg::rate_t out_rate_now
);
  import tasrl_pkg::*;

  // A pending result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A pending result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_azimuth_now) && $stable(out_elevation_now)
      && $stable(out_in_motion) && $stable(out_rate_now))
    else $error("result payload changed while stalled");

  // The reported rate is zero whenever the positioner is not moving.
  a_rate_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_motion |-> out_rate_now == '0)
    else $error("nonzero rate reported while not moving");

  // Moving means a step above one unit, so the reported rate must exceed one.
  a_rate_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_motion |-> out_rate_now > RateW'(1))
    else $error("moving reported with a rate of one or less");

  // Reset empties the pipe and leaves the input open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipe not empty after reset");

endmodule

bind two_axis_slew_rate_limiter_top tasrl_checker u_tasrl_checker (.*);
`default_nettype wire

@@ dv/tb_two_axis_slew_rate_limiter_top.sv @@
// Self-checking testbench for the two-axis slew-rate limited positioner.
`timescale 1ns / 1ps
module tb_two_axis_slew_rate_limiter_top;
  import tasrl_pkg::*;

  // The unused item kind has no name in the package, so it gets one here.
  localparam logic [1:0] KindUnused = 2'd3;
  // A tick's result is presented from the output register once its item leaves the stage, and
  // these spare cycles cover items that leave no result behind.
  localparam int SettleCycles = 6;
  localparam int CycleLimit   = 200000;

  // One input item as the sender sees it.
  typedef struct {
    logic [1:0] kind;
    pos_t       az;
    pos_t       el;
    rate_t      rate;
  } command_t;

  // One position report as the block should send it.
  typedef struct {
    pos_t  az;
    pos_t  el;
    logic  motion;
    rate_t rate;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  pos_t        in_want_azimuth;
  pos_t        in_want_elevation;
  rate_t       in_want_rate;
  logic        out_valid;
  logic        out_ready;
  pos_t        out_azimuth_now;
  pos_t        out_elevation_now;
  logic        out_in_motion;
  rate_t       out_rate_now;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [18:0] cfg_data;

  two_axis_slew_rate_limiter_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_want_azimuth   (in_want_azimuth),
    .in_want_elevation (in_want_elevation),
    .in_want_rate      (in_want_rate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_azimuth_now   (out_azimuth_now),
    .out_elevation_now (out_elevation_now),
    .out_in_motion     (out_in_motion),
    .out_rate_now      (out_rate_now),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Shadow copy of the limit registers.
  int az_limit;
  int el_limit;
  int rate_floor;
  int rate_ceiling;

  // Shadow copy of the positioner state.
  int   az_pos;
  int   el_pos;
  int   az_goal;
  int   el_goal;
  int   goal_rate;
  logic moving;
  int   shown_rate;
  logic halted;

  // Position reports still owed by the block, oldest first.
  report_t pending_reports[$];
  report_t oldest_report;

  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int stall_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Clamp a requested goal to the symmetric window of the limit register.
  function automatic int limit_goal(int want, int lim);
    if (want > lim) return lim;
    if (want < -lim) return -lim;
    return want;
  endfunction

  // One axis heads for its goal by at most one rate step per tick.
  function automatic int step_toward(int cur, int goal, int step);
    int diff;
    int mag;
    diff = goal - cur;
    mag  = (diff < 0) ? -diff : diff;
    if (mag <= step) return goal;
    return (diff > 0) ? cur + step : cur - step;
  endfunction

  // Update the shadow state for one taken item and queue the report it owes.
  function automatic void advance_positioner(command_t c);
    int r;
    int next_az;
    int next_el;
    int d_az;
    int d_el;
    case (c.kind)
      KIND_SET: begin
        r = int'(c.rate);
        if (r < rate_floor) r = rate_floor;
        if (r > rate_ceiling) r = rate_ceiling;
        az_goal   = limit_goal(int'(c.az), az_limit);
        el_goal   = limit_goal(int'(c.el), el_limit);
        goal_rate = r;
        halted    = 1'b0;
      end
      KIND_STOP: begin
        halted     = 1'b1;
        az_goal    = az_pos;
        el_goal    = el_pos;
        goal_rate  = 0;
        moving     = 1'b0;
        shown_rate = 0;
      end
      KIND_TICK: begin
        if (!halted) begin
          next_az    = step_toward(az_pos, az_goal, goal_rate);
          next_el    = step_toward(el_pos, el_goal, goal_rate);
          d_az       = next_az - az_pos;
          d_el       = next_el - el_pos;
          az_pos     = next_az;
          el_pos     = next_el;
          moving     = (d_az > 1) || (d_az < -1) || (d_el > 1) || (d_el < -1);
          shown_rate = moving ? goal_rate : 0;
        end
        pending_reports.push_back('{pos_t'(az_pos), pos_t'(el_pos), moving,
                                   rate_t'(shown_rate)});
      end
      default: begin
        // The unused kind is dropped by the block without any effect.
      end
    endcase
  endfunction

  // Receiver side: drive out_ready and check every report the block hands over.
  // Values read here are the ones present at the edge, since all drives are
  // nonblocking and have not yet been applied in this time step.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with nothing expected: az %0d el %0d motion %0b rate %0d",
                 $time, out_azimuth_now, out_elevation_now, out_in_motion, out_rate_now);
        errors++;
      end else begin
        oldest_report = pending_reports.pop_front();
        if (out_azimuth_now !== oldest_report.az) begin
          $display("%0t: azimuth expected %0d actual %0d",
                   $time, oldest_report.az, out_azimuth_now);
          errors++;
        end
        if (out_elevation_now !== oldest_report.el) begin
          $display("%0t: elevation expected %0d actual %0d",
                   $time, oldest_report.el, out_elevation_now);
          errors++;
        end
        if (out_in_motion !== oldest_report.motion) begin
          $display("%0t: in_motion expected %0b actual %0b",
                   $time, oldest_report.motion, out_in_motion);
          errors++;
        end
        if (out_rate_now !== oldest_report.rate) begin
          $display("%0t: rate expected %0d actual %0d",
                   $time, oldest_report.rate, out_rate_now);
          errors++;
        end
      end
    end
    // A long hold-off, counted down here, takes priority over random stalls.
    if (stall_hold > 0) begin
      stall_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item, wait for it to be taken, then account for it.
  // Called at a rising edge; valid is only lowered when a gap is inserted.
  task automatic send_item(logic [1:0] kind, pos_t az, pos_t el, rate_t rate);
    command_t c;
    c = '{kind, az, el, rate};
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_want_azimuth   <= az;
    in_want_elevation <= el;
    in_want_rate      <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_positioner(c);
  endtask

  // Stop offering items and wait until every owed report is in and the
  // pipeline has had time to finish any item that owes nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[18:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AZ_LIMIT:   az_limit     = value;
      CFG_EL_LIMIT:   el_limit     = value;
      CFG_RATE_FLOOR: rate_floor   = value;
      CFG_RATE_CEIL:  rate_ceiling = value;
      default: ;
    endcase
  endtask

  // Rewrite all four limit registers; only ever called with the block idle.
  task automatic set_limits(int az_lim, int el_lim, int floor_v, int ceil_v);
    settle();
    cfg_write(CFG_AZ_LIMIT, az_lim);
    cfg_write(CFG_EL_LIMIT, el_lim);
    cfg_write(CFG_RATE_FLOOR, floor_v);
    cfg_write(CFG_RATE_CEIL, ceil_v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pos_t random_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return pos_t'(int'($urandom_range(720000)) - 360000);
    if (pick < 85) return pos_t'(int'($urandom_range(6)) - 3);
    case ($urandom_range(3))
      0: return pos_t'(360000);
      1: return pos_t'(-360000);
      2: return pos_t'(-524288);
      default: return pos_t'(524287);
    endcase
  endfunction

  function automatic rate_t random_rate();
    if ($urandom_range(99) < 40) return rate_t'($urandom_range(3));
    return rate_t'($urandom_range(65535));
  endfunction

  task automatic send_tick();
    send_item(KIND_TICK, '0, '0, '0);
  endtask

  // Right after reset the goal equals the position and the rate is zero.
  task automatic test_reset_state();
    send_tick();
  endtask

  // Goal and rate clamping against the default limits, and the motion flag
  // that only rises when an axis moves by more than one unit.
  task automatic test_goal_clamping();
    send_item(KIND_SET, pos_t'(1000), pos_t'(-500), rate_t'(0));
    send_tick();
    send_tick();
    send_item(KIND_SET, pos_t'(360000), pos_t'(-360000), rate_t'(65535));
    send_tick();
    send_item(KIND_SET, pos_t'(-524288), pos_t'(524287), rate_t'(2));
    send_tick();
    send_item(KindUnused, pos_t'(-1), pos_t'(-1), rate_t'(65535));
    send_tick();
  endtask

  // An emergency stop freezes everything until the next set-target item.
  task automatic test_emergency_stop();
    send_item(KIND_STOP, '0, '0, '0);
    send_tick();
    send_tick();
    send_item(KIND_SET, pos_t'(0), pos_t'(0), rate_t'(600));
    send_tick();
  endtask

  // Floor above ceiling lets the ceiling win; a zero rate leaves axes in place.
  task automatic test_rate_window();
    set_limits(180000, 90000, 5000, 100);
    send_item(KIND_SET, pos_t'(50), pos_t'(50), rate_t'(3000));
    send_tick();
    set_limits(180000, 90000, 0, 0);
    send_item(KIND_SET, pos_t'(10), pos_t'(-10), rate_t'(0));
    send_tick();
  endtask

  // Position limits at zero and at 360000, rate limits at both ends of their range.
  task automatic test_limit_extremes();
    set_limits(0, 0, 0, 65535);
    send_item(KIND_SET, pos_t'(360000), pos_t'(-360000), rate_t'(65535));
    send_tick();
    set_limits(360000, 360000, 65535, 65535);
    send_item(KIND_SET, pos_t'(360000), pos_t'(-360000), rate_t'(1));
    send_tick();
    send_tick();
  endtask

  // Random traffic: mostly a set-target item followed by a run of ticks,
  // with stops and unused kinds mixed in now and then.
  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    int run;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(KindUnused, random_angle(), random_angle(), random_rate());
      end else if (pick < 12) begin
        send_item(KIND_STOP, random_angle(), random_angle(), random_rate());
        sent++;
      end else if (pick < 20) begin
        send_tick();
        sent++;
      end else begin
        send_item(KIND_SET, random_angle(), random_angle(), random_rate());
        sent++;
        run = $urandom_range(8, 1);
        repeat (run) send_tick();
        sent += run;
      end
    end
  endtask

  // The receiver holds off while ticks keep coming, so the block fills and
  // stalls its input; afterwards the sender waits until all reports are in.
  task automatic test_backpressure();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_hold     = 250;
    send_item(KIND_SET, pos_t'(-20000), pos_t'(15000), rate_t'(65535));
    repeat (30) send_tick();
    settle();
    repeat (10) send_tick();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= KIND_TICK;
    in_want_azimuth   <= '0;
    in_want_elevation <= '0;
    in_want_rate      <= '0;
    out_ready         <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_AZ_LIMIT;
    cfg_data          <= '0;
    errors            = 0;
    cycles            = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    stall_hold        = 0;
    az_limit          = int'(AzLimitRst);
    el_limit          = int'(ElLimitRst);
    rate_floor        = int'(RateFloorRst);
    rate_ceiling      = int'(RateCeilRst);
    az_pos            = 0;
    el_pos            = 0;
    az_goal           = 0;
    el_goal           = 0;
    goal_rate         = 0;
    moving            = 1'b0;
    shown_rate        = 0;
    halted            = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks run with the default limits first.
    test_reset_state();
    test_goal_clamping();
    test_emergency_stop();
    test_rate_window();
    test_limit_extremes();

    // Random phases, each with its own limits and idling pattern.
    set_limits($urandom_range(360000), $urandom_range(360000),
               $urandom_range(200), $urandom_range(65535));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(90);

    set_limits($urandom_range(360000), $urandom_range(360000),
               $urandom_range(65535), $urandom_range(65535));
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    test_random_traffic(90);

    set_limits(360000, 360000, 0, 65535);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    test_random_traffic(90);

    set_limits($urandom_range(360000), $urandom_range(360000),
               $urandom_range(20), $urandom_range(2000));
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    test_random_traffic(90);

    test_backpressure();

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ two_axis_slew_rate_limiter_top.f @@
src/tasrl_pkg.sv
src/tasrl_axis.sv
src/two_axis_slew_rate_limiter_top.sv
src/tasrl_checker.sv
dv/tb_two_axis_slew_rate_limiter_top.sv
